[hdl/swst_pkg.sv]
package swst_pkg;

  // Angle and stage settings
  localparam int ANGLE_BITS    = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int STAGES        = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
  localparam int OUT_BITS      = (ANGLE_BITS < 16) ? ANGLE_BITS : 16;
  localparam int ROUND_POS     = 32 - OUT_BITS;

  localparam int NWHEEL = 4;
  localparam int ROT_W  = 34;
  localparam int VEC_W  = 38;
  localparam int SIDE_W = 48;

  // CORDIC gain compensation, Q30
  localparam logic signed [31:0] GAIN_Q30 =
    32'(652032875 + (434688583 >> (2 * STAGES)));

  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [31:0] ROUND_HALF   = 32'(1) << (ROUND_POS - 1);
  localparam logic [31:0] ROUND_MASK   = ~((32'(1) << ROUND_POS) - 32'(1));

  localparam logic [31:0] ATAN_TAB [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  localparam logic [31:0] MOUNT_TAB [NWHEEL] = '{
    32'h2000_0000, 32'h6000_0000, 32'hA000_0000, 32'hE000_0000
  };

  typedef logic signed [ROT_W-1:0] rot_t;
  typedef logic signed [VEC_W-1:0] vec_t;

endpackage

[hdl/swst_rot.sv]
module swst_rot (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic signed [31:0]        in_x,
  input  logic [31:0]               in_ang [swst_pkg::NWHEEL],
  input  logic [swst_pkg::SIDE_W-1:0] in_side,
  output logic                      out_valid,
  output swst_pkg::rot_t            out_x [swst_pkg::NWHEEL],
  output swst_pkg::rot_t            out_y [swst_pkg::NWHEEL],
  output logic [swst_pkg::SIDE_W-1:0] out_side
);
  import swst_pkg::*;

  logic              v_r    [STAGES+1];
  logic [SIDE_W-1:0] side_r [STAGES+1];
  rot_t              x_r    [STAGES+1][NWHEEL];
  rot_t              y_r    [STAGES+1][NWHEEL];
  rot_t              z_r    [STAGES+1][NWHEEL];

  // Fold second and third quadrants onto the right half plane
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      for (int k = 0; k < NWHEEL; k++) begin
        y_r[0][k] <= '0;
        if (in_ang[k][31] != in_ang[k][30]) begin
          x_r[0][k] <= -ROT_W'(in_x);
          z_r[0][k] <= ROT_W'($signed(in_ang[k] ^ HALF_TURN));
        end else begin
          x_r[0][k] <= ROT_W'(in_x);
          z_r[0][k] <= ROT_W'($signed(in_ang[k]));
        end
      end
    end
  end

  // Valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= STAGES; s++) v_r[s] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int s = 0; s < STAGES; s++) v_r[s+1] <= v_r[s];
    end
  end

  // One micro-rotation per stage
  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    rot_t dx [NWHEEL];
    rot_t dy [NWHEEL];
    always_comb begin
      for (int k = 0; k < NWHEEL; k++) begin
        dx[k] = y_r[i][k] >>> i;
        dy[k] = x_r[i][k] >>> i;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        side_r[i+1] <= side_r[i];
        for (int k = 0; k < NWHEEL; k++) begin
          if (!z_r[i][k][ROT_W-1]) begin
            x_r[i+1][k] <= x_r[i][k] - dx[k];
            y_r[i+1][k] <= y_r[i][k] + dy[k];
            z_r[i+1][k] <= z_r[i][k] - ROT_W'(ATAN_TAB[i]);
          end else begin
            x_r[i+1][k] <= x_r[i][k] + dx[k];
            y_r[i+1][k] <= y_r[i][k] - dy[k];
            z_r[i+1][k] <= z_r[i][k] + ROT_W'(ATAN_TAB[i]);
          end
        end
      end
    end
  end

  assign out_valid = v_r[STAGES];
  assign out_side  = side_r[STAGES];
  always_comb begin
    for (int k = 0; k < NWHEEL; k++) begin
      out_x[k] = x_r[STAGES][k];
      out_y[k] = y_r[STAGES][k];
    end
  end

endmodule

[hdl/swst_vec.sv]
module swst_vec (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  swst_pkg::vec_t in_x [swst_pkg::NWHEEL],
  input  swst_pkg::vec_t in_y [swst_pkg::NWHEEL],
  input  logic [15:0]    in_head,
  output logic           out_valid,
  output logic [31:0]    out_ang [swst_pkg::NWHEEL],
  output logic [15:0]    out_head
);
  import swst_pkg::*;

  logic        v_r    [STAGES+1];
  logic [15:0] head_r [STAGES+1];
  vec_t        x_r    [STAGES+1][NWHEEL];
  vec_t        y_r    [STAGES+1][NWHEEL];
  logic [31:0] z_r    [STAGES+1][NWHEEL];
  logic        zero_r [STAGES+1][NWHEEL];

  // Map into the right half plane and flag the zero vector
  always_ff @(posedge clk) begin
    if (en) begin
      head_r[0] <= in_head;
      for (int k = 0; k < NWHEEL; k++) begin
        zero_r[0][k] <= (in_x[k] == '0) && (in_y[k] == '0);
        if (in_x[k][VEC_W-1]) begin
          x_r[0][k] <= -in_x[k];
          y_r[0][k] <= -in_y[k];
          z_r[0][k] <= HALF_TURN;
        end else begin
          x_r[0][k] <= in_x[k];
          y_r[0][k] <= in_y[k];
          z_r[0][k] <= '0;
        end
      end
    end
  end

  // Valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= STAGES; s++) v_r[s] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int s = 0; s < STAGES; s++) v_r[s+1] <= v_r[s];
    end
  end

  // One vectoring step per stage
  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    vec_t dx [NWHEEL];
    vec_t dy [NWHEEL];
    always_comb begin
      for (int k = 0; k < NWHEEL; k++) begin
        dx[k] = y_r[i][k] >>> i;
        dy[k] = x_r[i][k] >>> i;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        head_r[i+1] <= head_r[i];
        for (int k = 0; k < NWHEEL; k++) begin
          zero_r[i+1][k] <= zero_r[i][k];
          if (y_r[i][k] > 0) begin
            x_r[i+1][k] <= x_r[i][k] + dx[k];
            y_r[i+1][k] <= y_r[i][k] - dy[k];
            z_r[i+1][k] <= z_r[i][k] + ATAN_TAB[i];
          end else begin
            x_r[i+1][k] <= x_r[i][k] - dx[k];
            y_r[i+1][k] <= y_r[i][k] + dy[k];
            z_r[i+1][k] <= z_r[i][k] - ATAN_TAB[i];
          end
        end
      end
    end
  end

  assign out_valid = v_r[STAGES];
  assign out_head  = head_r[STAGES];
  always_comb begin
    for (int k = 0; k < NWHEEL; k++) begin
      out_ang[k] = zero_r[STAGES][k] ? 32'h0 : z_r[STAGES][k];
    end
  end

endmodule

[hdl/swerve_steer_angle_kinematics.sv]
// Four-wheel swerve steering angles: one beat in, one beat out, a new beat
// every cycle unless stalled. Stages: two multiply stages, a rotation CORDIC
// and a vectoring CORDIC of one stage per iteration each plus a fold stage, a
// velocity add, and the output register. The whole pipeline advances together
// and holds while a result waits at the output. The user must write arm_offset
// through cfg_wr_en/cfg_wr_data while idle; the block does not enforce it.
module swerve_steer_angle_kinematics (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_vel_x,
  input  logic signed [15:0] in_vel_y,
  input  logic signed [15:0] in_yaw_rate,
  input  logic signed [15:0] in_heading,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_angle_front_left,
  output logic signed [15:0] out_angle_rear_left,
  output logic signed [15:0] out_angle_rear_right,
  output logic signed [15:0] out_angle_front_right
);
  import swst_pkg::*;

  logic               en;
  logic [15:0]        arm_r;
  logic               va_r, vb_r, vs_r, out_valid_r;
  logic signed [31:0] r_r, rk_r;
  logic [SIDE_W-1:0]  sa_r, sb_r;
  logic signed [63:0] rk_prod;
  logic [31:0]        ang [NWHEEL];
  logic               rot_valid;
  rot_t               tx [NWHEEL];
  rot_t               ty [NWHEEL];
  logic [SIDE_W-1:0]  rot_side;
  vec_t               vtx_r [NWHEEL];
  vec_t               vty_r [NWHEEL];
  logic [15:0]        hs_r;
  logic               vec_valid;
  logic [31:0]        vang [NWHEEL];
  logic [15:0]        vhead;
  logic [15:0]        res_r [NWHEEL];

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arm_r <= 16'd9268;
    end else if (cfg_wr_en) begin
      arm_r <= cfg_wr_data;
    end
  end

  // Valid bits of the local stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      vs_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      va_r        <= in_valid;
      vb_r        <= va_r;
      vs_r        <= rot_valid;
      out_valid_r <= vec_valid;
    end
  end

  // Tangential speed, then gain compensation
  assign rk_prod = 64'(r_r) * 64'(GAIN_Q30);

  always_ff @(posedge clk) begin
    if (en) begin
      r_r  <= 32'($signed({1'b0, arm_r}) * in_yaw_rate);
      sa_r <= {in_heading, in_vel_x, in_vel_y};
      rk_r <= rk_prod[61:30];
      sb_r <= sa_r;
    end
  end

  // Rotation angle of each wheel: heading plus mount angle plus a quarter turn
  always_comb begin
    for (int k = 0; k < NWHEEL; k++) begin
      ang[k] = {sb_r[47:32], 16'h0} + MOUNT_TAB[k] + QUARTER_TURN;
    end
  end

  swst_rot u_rot (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vb_r),
    .in_x      (rk_r),
    .in_ang    (ang),
    .in_side   (sb_r),
    .out_valid (rot_valid),
    .out_x     (tx),
    .out_y     (ty),
    .out_side  (rot_side)
  );

  // Add the rotational term to the world velocity
  always_ff @(posedge clk) begin
    if (en) begin
      hs_r <= rot_side[47:32];
      for (int k = 0; k < NWHEEL; k++) begin
        vtx_r[k] <= (VEC_W'($signed(rot_side[31:16])) <<< 18) + VEC_W'(tx[k]);
        vty_r[k] <= (VEC_W'($signed(rot_side[15:0])) <<< 18) + VEC_W'(ty[k]);
      end
    end
  end

  swst_vec u_vec (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vs_r),
    .in_x      (vtx_r),
    .in_y      (vty_r),
    .in_head   (hs_r),
    .out_valid (vec_valid),
    .out_ang   (vang),
    .out_head  (vhead)
  );

  // Subtract heading and a quarter turn, round, hold in the output register
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NWHEEL; k++) begin
        res_r[k] <= 16'((((vang[k] - {vhead, 16'h0} - QUARTER_TURN) + ROUND_HALF)
                         & ROUND_MASK) >> 16);
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_angle_front_left  = res_r[0];
  assign out_angle_rear_left   = res_r[1];
  assign out_angle_rear_right  = res_r[2];
  assign out_angle_front_right = res_r[3];

  // A waiting result stalls the whole pipeline
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_angle_front_left)
      && $stable(out_angle_rear_right))
    else $error("output changed during stall");

  a_stall_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipeline stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !vs_r && !va_r)
    else $error("pipeline not empty after reset");

  a_advance_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> va_r)
    else $error("accepted beat lost at first stage");

endmodule

[bench/swerve_steer_angle_kinematics_test.sv]
module swerve_steer_angle_kinematics_test;
  timeunit 1ns;
  timeprecision 1ps;

  import swst_pkg::*;

  typedef struct packed {
    logic signed [15:0] fl;
    logic signed [15:0] rl;
    logic signed [15:0] rr;
    logic signed [15:0] fr;
  } steer_set_t;

  // Fixed-point steering model plus the queue of steer sets still owed
  class steer_board;
    logic [15:0] arm;
    steer_set_t  owed[$];
    int          errors;

    function new();
      arm = 16'd9268;
      errors = 0;
    endfunction

    static function longint asr(longint v, int n);
      return v >>> n;
    endfunction

    static function void rotate(longint x0, logic [31:0] a, output longint ox,
                                output longint oy);
      longint x, y, z, dx, dy;
      logic [1:0] q;
      x = x0;
      y = 0;
      q = a[31:30];
      if (q == 2'd1 || q == 2'd2) begin
        x = -x;
        a = a + HALF_TURN;
      end
      z = longint'(signed'(a));
      for (int i = 0; i < STAGES; i++) begin
        dx = asr(y, i);
        dy = asr(x, i);
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
        end else begin
          x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
        end
      end
      ox = x;
      oy = y;
    endfunction

    static function logic [31:0] bearing(longint y, longint x);
      logic [31:0] z;
      longint dx, dy;
      z = 0;
      if (x == 0 && y == 0) return 32'd0;
      if (x < 0) begin
        x = -x; y = -y; z = HALF_TURN;
      end
      for (int i = 0; i < STAGES; i++) begin
        dx = asr(y, i);
        dy = asr(x, i);
        if (y > 0) begin
          x += dx; y -= dy; z += ATAN_TAB[i];
        end else begin
          x -= dx; y += dy; z -= ATAN_TAB[i];
        end
      end
      return z;
    endfunction

    function void note_command(logic signed [15:0] vx, logic signed [15:0] vy,
                               logic signed [15:0] w, logic signed [15:0] hd);
      longint fx, fy, r, rk, tx, ty;
      logic [31:0] head, m, a, qv;
      logic [15:0] ang[4];
      steer_set_t s;
      fx = longint'(vx) * (64'sd1 <<< 18);
      fy = longint'(vy) * (64'sd1 <<< 18);
      head = {hd, 16'h0};
      r = longint'({1'b0, arm}) * longint'(w);
      rk = asr(r * longint'(GAIN_Q30), 30);
      for (int k = 0; k < NWHEEL; k++) begin
        m = head + MOUNT_TAB[k];
        rotate(rk, m + QUARTER_TURN, tx, ty);
        a = bearing(fy + ty, fx + tx) - head - QUARTER_TURN;
        qv = (a + ROUND_HALF) & ROUND_MASK;
        ang[k] = qv[31:16];
      end
      s.fl = ang[0]; s.rl = ang[1]; s.rr = ang[2]; s.fr = ang[3];
      owed.push_back(s);
    endfunction

    function void check_steer(steer_set_t got);
      steer_set_t e;
      if (owed.size() == 0) begin
        $display("%0t: unexpected steer beat, actual %h", $time, got);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (got.fl !== e.fl) begin
        $display("%0t: front_left expected %0d actual %0d", $time, e.fl, got.fl);
        errors++;
      end
      if (got.rl !== e.rl) begin
        $display("%0t: rear_left expected %0d actual %0d", $time, e.rl, got.rl);
        errors++;
      end
      if (got.rr !== e.rr) begin
        $display("%0t: rear_right expected %0d actual %0d", $time, e.rr, got.rr);
        errors++;
      end
      if (got.fr !== e.fr) begin
        $display("%0t: front_right expected %0d actual %0d", $time, e.fr, got.fr);
        errors++;
      end
    endfunction
  endclass

  localparam int LATENCY = 2 * CORDIC_STAGES + 6;
  localparam int CYCLE_LIMIT = 400000;

  logic clk, rst_n;
  logic cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [15:0] in_vel_x, in_vel_y, in_yaw_rate, in_heading;
  logic signed [15:0] out_fl, out_rl, out_rr, out_fr;

  steer_board board;
  int  idle_pct;      // sender idle percentage
  int  sink_pct;      // receiver stall percentage
  bit  sink_hold;     // long receiver hold-off
  longint cycles;

  swerve_steer_angle_kinematics u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_vel_x(in_vel_x), .in_vel_y(in_vel_y),
    .in_yaw_rate(in_yaw_rate), .in_heading(in_heading),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_angle_front_left(out_fl), .out_angle_rear_left(out_rl),
    .out_angle_rear_right(out_rr), .out_angle_front_right(out_fr)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("** swerve_steer_angle_kinematics: FAILED **");
        $finish;
      end
    end
  end

  // Receiver: random stalls, optional long hold-off, check each beat
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        board.check_steer({out_fl, out_rl, out_rr, out_fr});
      out_ready <= !sink_hold && ($urandom_range(99) >= sink_pct);
    end
  end

  // Offer one beat; valid stays high into the next beat unless the sender idles
  task automatic send_command(logic signed [15:0] vx, logic signed [15:0] vy,
                              logic signed [15:0] w, logic signed [15:0] hd);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_vel_x <= vx; in_vel_y <= vy; in_yaw_rate <= w; in_heading <= hd;
    do @(posedge clk); while (!in_ready);
    board.note_command(vx, vy, w, hd);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.owed.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_arm(logic [15:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.arm = v;
  endtask

  task automatic random_command();
    logic signed [15:0] vx, vy, w, hd;
    vx = 16'($urandom); vy = 16'($urandom); w = 16'($urandom); hd = 16'($urandom);
    case ($urandom_range(5))
      0: begin vx = 0; vy = 0; end
      1: w = 0;
      2: begin
        vx = 16'($urandom_range(1023) - 512);
        vy = 16'($urandom_range(1023) - 512);
      end
      3: w = 16'($urandom_range(255) - 128);
      default: ;
    endcase
    send_command(vx, vy, w, hd);
  endtask

  initial begin
    logic signed [15:0] ext[4];
    logic [15:0] arms[5];
    ext[0] = -16'sd32768; ext[1] = 16'sd32767; ext[2] = 0; ext[3] = -16'sd1;
    arms[0] = 16'd0; arms[1] = 16'hFFFF; arms[2] = 16'd1;
    arms[3] = 16'd16384; arms[4] = 16'd9268;
    board = new();
    rst_n = 1'b0;
    cfg_wr_en = 1'b0; cfg_wr_data = '0;
    in_valid = 1'b0;
    in_vel_x = '0; in_vel_y = '0; in_yaw_rate = '0; in_heading = '0;
    idle_pct = 0; sink_pct = 0; sink_hold = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero vector, field extremes, pure rotation, wrap headings
    send_command(0, 0, 0, 0);
    send_command(0, 0, 0, -16'sd32768);
    send_command(256, 0, 0, 0);
    send_command(0, 256, 0, 16'sd16384);
    send_command(0, 0, 16'sd4096, 0);
    send_command(0, 0, -16'sd4096, 16'sd8192);
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        send_command(ext[i], ext[j], ext[(i + j) % 4], ext[(i + 3 * j) % 4]);
    drain();

    // Random phases over several arm settings
    idle_pct = 33; sink_pct = 33;
    for (int p = 0; p < 5; p++) begin
      write_arm(arms[p]);
      if (p == 2) begin
        idle_pct = 0; sink_pct = 0;
      end else begin
        idle_pct = 33; sink_pct = 33;
      end
      if (p == 3) begin
        // Fill the pipeline against a stalled receiver
        idle_pct = 0;
        fork
          begin
            sink_hold = 1'b1;
            repeat (120) @(posedge clk);
            sink_hold = 1'b0;
          end
          for (int n = 0; n < 80; n++) random_command();
        join
        idle_pct = 33;
      end
      for (int n = 0; n < 220; n++) random_command();
      drain();
    end

    if (board.errors == 0 && board.owed.size() == 0)
      $display("** swerve_steer_angle_kinematics: PASSED **");
    else
      $display("** swerve_steer_angle_kinematics: FAILED **");
    $finish;
  end
endmodule
